### hdl/vryb_pkg.sv
`default_nettype none

package vryb_pkg;

  // Stream and configuration widths
  localparam int unsigned IN_W   = 152;
  localparam int unsigned OUT_W  = 176;
  localparam int unsigned CFG_AW = 3;

  // Grid extent
  localparam int unsigned GRID_CELLS  = 256;
  localparam int unsigned GRID_LAYERS = 64;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_CELL_XY  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CELL_Z   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_X = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FLOOR_Z  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DENS_THR = 3'd5;
  localparam logic [CFG_AW-1:0] REG_WHITE    = 3'd6;

  // Divider: one setup stage plus one stage per quotient bit
  localparam int unsigned QUO_W    = 15;
  localparam int unsigned DIV_LAST = QUO_W;
  localparam int unsigned LAST_STG = DIV_LAST + 3;

  localparam logic [15:0] ONE_Q15 = 16'd32768;

  typedef logic [2:0][15:0] rgb_t;

  // RYB cube corner colors, channel 0 is red
  function automatic rgb_t corner_rgb(input logic r, input logic y, input logic b);
    rgb_t c;
    case ({r, y, b})
      3'b000:  c = {16'd32768, 16'd32768, 16'd32768};
      3'b100:  c = {16'd0,     16'd0,     16'd32768};
      3'b010:  c = {16'd0,     16'd32768, 16'd32768};
      3'b001:  c = {16'd19661, 16'd12222, 16'd5341};
      3'b110:  c = {16'd0,     16'd16384, 16'd32768};
      3'b101:  c = {16'd16384, 16'd0,     16'd16384};
      3'b011:  c = {16'd6554,  16'd21627, 16'd0};
      3'b111:  c = {16'd950,   16'd3080,  16'd6554};
      default: c = '0;
    endcase
    return c;
  endfunction

  // Add half-cell offset product to a signed base, saturate high
  function automatic logic [31:0] centre_sat(input logic [31:0] base, input logic [40:0] prod);
    logic signed [41:0] p;
    p = $signed({{10{base[31]}}, base}) + $signed({2'b00, prod[40:1]});
    if (p > $signed(42'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
    return p[31:0];
  endfunction

endpackage

`default_nettype wire

### hdl/voxel_ryb_colorize_emit_core.sv
`default_nettype none

// RYB voxel colorizer: takes one voxel per cycle on s_axis and emits at most one point on
// m_axis, except while the output item waits. The datapath is a 15-stage restoring divider
// (one quotient bit per stage, three pigments in parallel) followed by three interpolation
// stages (blue, yellow, red) and an output stage. Voxels outside the grid, at or below the
// density threshold, or mixing to near white are dropped. The whole pipeline holds while
// the output item waits. Config is written through cfg_* (always ready) and must only
// change while the pipeline is empty.
module voxel_ryb_colorize_emit_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // cell_x[7:0], cell_y[15:8], cell_z[21:16], density[53:22], red_premul[85:54],
  // yellow_premul[117:86], blue_premul[149:118], zero pad
  input  logic [vryb_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // world_x[31:0], world_y[63:32], world_z[95:64], out_red[111:96],
  // out_green[127:112], out_blue[143:128], point_width[175:144]
  output logic [vryb_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [vryb_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0]                cfg_data_i
);
  import vryb_pkg::*;

  // Configuration registers
  logic [31:0] cell_xy_q, cell_z_q, origin_x_q, origin_y_q, floor_z_q, dens_thr_q;
  logic [15:0] white_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_xy_q  <= 32'd65536;
      cell_z_q   <= 32'd65536;
      origin_x_q <= '0;
      origin_y_q <= '0;
      floor_z_q  <= '0;
      dens_thr_q <= 32'd66;
      white_q    <= 16'd29491;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_CELL_XY:  cell_xy_q  <= cfg_data_i;
        REG_CELL_Z:   cell_z_q   <= cfg_data_i;
        REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        REG_FLOOR_Z:  floor_z_q  <= cfg_data_i;
        REG_DENS_THR: dens_thr_q <= cfg_data_i;
        REG_WHITE:    white_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input unpack
  logic [7:0]  in_cx, in_cy;
  logic [5:0]  in_cz;
  logic [31:0] in_dens;
  logic [2:0][31:0] in_pre;

  assign in_cx     = s_axis_tdata[7:0];
  assign in_cy     = s_axis_tdata[15:8];
  assign in_cz     = s_axis_tdata[21:16];
  assign in_dens   = s_axis_tdata[53:22];
  assign in_pre[0] = s_axis_tdata[85:54];
  assign in_pre[1] = s_axis_tdata[117:86];
  assign in_pre[2] = s_axis_tdata[149:118];

  // Pipeline advances together whenever the output register is free
  logic out_vld_q;
  logic adv;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic              vld_q  [0:LAST_STG];
  logic              keep_q [0:LAST_STG];
  logic [31:0]       dens_q [0:LAST_STG];
  logic [2:0][31:0]  wld_q  [0:LAST_STG];
  logic [2:0][40:0]  prod_q;

  logic [2:0]            sat_q [0:DIV_LAST];
  logic [2:0][31:0]      rem_q [0:DIV_LAST];
  logic [2:0][QUO_W-1:0] quo_q [0:DIV_LAST];
  logic [2:0][31:0]      rem_d [1:DIV_LAST];
  logic [2:0][QUO_W-1:0] quo_d [1:DIV_LAST];

  // One restoring division step per stage and pigment
  always_comb begin
    logic [32:0] rem2;
    logic        ge;
    for (int s = 1; s <= DIV_LAST; s++) begin
      for (int c = 0; c < 3; c++) begin
        rem2 = {rem_q[s-1][c], 1'b0};
        ge   = rem2 >= {1'b0, dens_q[s-1]};
        rem_d[s][c] = ge ? 32'(rem2 - {1'b0, dens_q[s-1]}) : rem2[31:0];
        quo_d[s][c] = {quo_q[s-1][c][QUO_W-2:0], ge};
      end
    end
  end

  // Normalized pigments leaving the divider
  logic [2:0][15:0] nrm;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nrm[c] = sat_q[DIV_LAST][c] ? ONE_Q15 : {1'b0, quo_q[DIV_LAST][c]};
    end
  end

  // Corner colors of the RYB cube, indexed by {r, y, b}
  rgb_t corner_tbl [8];
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      corner_tbl[k[2:0]] = corner_rgb(k[2], k[1], k[0]);
    end
  end

  // Interpolation registers: v over (r,y) corners, u over r, then the full sum
  logic [2:0][3:0][30:0] v_q;
  logic [2:0][1:0][45:0] u_q;
  logic [2:0][60:0]      acc_q;
  logic [15:0] fr16_q, fy16_q, fr17_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= LAST_STG; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int s = 1; s <= LAST_STG; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 0: screen, divider setup, position products
      keep_q[0] <= (32'(in_cx) < GRID_CELLS) && (32'(in_cy) < GRID_CELLS) &&
                   (32'(in_cz) < GRID_LAYERS) && (in_dens > dens_thr_q);
      dens_q[0] <= in_dens;
      wld_q[0]  <= '0;
      for (int c = 0; c < 3; c++) begin
        sat_q[0][c] <= in_pre[c] >= in_dens;
        rem_q[0][c] <= (in_pre[c] >= in_dens) ? 32'd0 : in_pre[c];
        quo_q[0][c] <= '0;
      end
      prod_q[0] <= 41'(41'({in_cx, 1'b1}) * 41'(cell_xy_q));
      prod_q[1] <= 41'(41'({in_cy, 1'b1}) * 41'(cell_xy_q));
      prod_q[2] <= 41'(41'({in_cz, 1'b1}) * 41'(cell_z_q));

      // Carry control and payload down the pipe
      for (int s = 1; s <= LAST_STG; s++) begin
        keep_q[s] <= keep_q[s-1];
        dens_q[s] <= dens_q[s-1];
      end
      wld_q[1][0] <= centre_sat(origin_x_q, prod_q[0]);
      wld_q[1][1] <= centre_sat(origin_y_q, prod_q[1]);
      wld_q[1][2] <= centre_sat(floor_z_q, prod_q[2]);
      for (int s = 2; s <= LAST_STG; s++) begin
        wld_q[s] <= wld_q[s-1];
      end

      // Divider steps
      for (int s = 1; s <= DIV_LAST; s++) begin
        sat_q[s] <= sat_q[s-1];
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
      end

      // Blue lerp on each (r,y) edge
      for (int ch = 0; ch < 3; ch++) begin
        for (int ry = 0; ry < 4; ry++) begin
          v_q[ch][ry] <=
            31'(31'(ONE_Q15 - nrm[2]) * 31'(corner_tbl[{ry[1:0], 1'b0}][ch])) +
            31'(31'(nrm[2]) * 31'(corner_tbl[{ry[1:0], 1'b1}][ch]));
        end
      end
      fr16_q <= nrm[0];
      fy16_q <= nrm[1];

      // Yellow lerp
      for (int ch = 0; ch < 3; ch++) begin
        for (int r = 0; r < 2; r++) begin
          u_q[ch][r] <= 46'(46'(ONE_Q15 - fy16_q) * 46'(v_q[ch][2*r])) +
                        46'(46'(fy16_q) * 46'(v_q[ch][2*r+1]));
        end
      end
      fr17_q <= fr16_q;

      // Red lerp
      for (int ch = 0; ch < 3; ch++) begin
        acc_q[ch] <= 61'(61'(ONE_Q15 - fr17_q) * 61'(u_q[ch][0])) +
                     61'(61'(fr17_q) * 61'(u_q[ch][1]));
      end
    end
  end

  // Round to Q1.15 and test for near white
  rgb_t rgb;
  logic white;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rgb[ch] = 16'((acc_q[ch] + 61'(64'd1 << 44)) >> 45);
    end
    white = (rgb[0] >= white_q) && (rgb[1] >= white_q) && (rgb[2] >= white_q);
  end

  // Output register
  logic [OUT_W-1:0] out_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[LAST_STG] && keep_q[LAST_STG] && !white;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {dens_q[LAST_STG], rgb[2], rgb[1], rgb[0],
                     wld_q[LAST_STG][2], wld_q[LAST_STG][1], wld_q[LAST_STG][0]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Emitted colors stay within one
  a_rgb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q[111:96] <= ONE_Q15) && (out_data_q[127:112] <= ONE_Q15) &&
                  (out_data_q[143:128] <= ONE_Q15))
    else $error("emitted color above one");

  // A near-white voxel never leaves the block
  a_not_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !((out_data_q[111:96] >= white_q) && (out_data_q[127:112] >= white_q) &&
                    (out_data_q[143:128] >= white_q)))
    else $error("near-white voxel emitted");

  // Divider remainder stays below the density for live voxels
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_LAST] && keep_q[DIV_LAST] |->
      (rem_q[DIV_LAST][0] < dens_q[DIV_LAST]) && (rem_q[DIV_LAST][1] < dens_q[DIV_LAST]) &&
      (rem_q[DIV_LAST][2] < dens_q[DIV_LAST]))
    else $error("divider remainder out of range");

  // An output item the sink refused is still offered next cycle
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q && $stable(out_data_q))
    else $error("stalled output item changed");

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vryb_pkg::*;

  typedef struct packed {
    logic [31:0] blue;
    logic [31:0] yellow;
    logic [31:0] red;
    logic [31:0] dens;
    logic [5:0]  cz;
    logic [7:0]  cy;
    logic [7:0]  cx;
  } voxel_t;

  typedef struct packed {
    logic [31:0] width;
    logic [15:0] b;
    logic [15:0] g;
    logic [15:0] r;
    logic [31:0] wz;
    logic [31:0] wy;
    logic [31:0] wx;
  } point_t;

  typedef enum logic [1:0] {ROW_NONE, ROW_PRED, ROW_GIVEN} row_kind_e;

  typedef struct {
    voxel_t    vox;
    row_kind_e kind;
    point_t    pt;
  } row_t;

  localparam int unsigned LIMIT = 400000;
  localparam int unsigned DRAIN = 40;
  localparam logic [CFG_AW-1:0] REG_SPARE = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_AW-1:0]  cfg_addr_i = '0;
  logic [31:0]        cfg_data_i = '0;

  // predictor copy of the registers
  logic [31:0] reg_q [7];
  point_t      pending_pts [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  logic [15:0] ryb_corner [8][3] = '{
    '{16'd32768, 16'd32768, 16'd32768},
    '{16'd5341,  16'd12222, 16'd19661},
    '{16'd32768, 16'd32768, 16'd0},
    '{16'd0,     16'd21627, 16'd6554},
    '{16'd32768, 16'd0,     16'd0},
    '{16'd16384, 16'd0,     16'd16384},
    '{16'd32768, 16'd16384, 16'd0},
    '{16'd6554,  16'd3080,  16'd950}
  };

  voxel_ryb_colorize_emit_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void reset_regs();
    reg_q[REG_CELL_XY]  = 32'd65536;
    reg_q[REG_CELL_Z]   = 32'd65536;
    reg_q[REG_ORIGIN_X] = 32'd0;
    reg_q[REG_ORIGIN_Y] = 32'd0;
    reg_q[REG_FLOOR_Z]  = 32'd0;
    reg_q[REG_DENS_THR] = 32'd66;
    reg_q[REG_WHITE]    = 32'd29491;
  endfunction

  // half-cell centre offset added to a signed base, saturated
  function automatic logic [31:0] cell_centre(logic [31:0] base, logic [7:0] idx,
                                              logic [31:0] size);
    longint off;
    longint p;
    off = longint'((64'(idx) * 2 + 1) * 64'(size)) >>> 1;
    p = longint'($signed(base)) + off;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  // normalize pigments, mix over the RYB cube, place the cell centre
  function automatic bit colorize(voxel_t v, output point_t pt);
    logic [31:0]        pre [3];
    logic [15:0]        fac [3][2];
    longint unsigned    q;
    longint unsigned    w;
    longint unsigned    acc [3];
    logic [15:0]        rgb [3];
    pt = '0;
    if (v.dens <= reg_q[REG_DENS_THR]) return 1'b0;
    pre = '{v.red, v.yellow, v.blue};
    for (int c = 0; c < 3; c++) begin
      q = (64'(pre[c]) << 15) / 64'(v.dens);
      fac[c][1] = (q > 32768) ? ONE_Q15 : q[15:0];
      fac[c][0] = ONE_Q15 - fac[c][1];
      acc[c] = 0;
    end
    for (int k = 0; k < 8; k++) begin
      w = 64'(fac[0][k[2]]) * 64'(fac[1][k[1]]) * 64'(fac[2][k[0]]);
      for (int c = 0; c < 3; c++) acc[c] += w * 64'(ryb_corner[k][c]);
    end
    for (int c = 0; c < 3; c++) rgb[c] = 16'((acc[c] + (64'd1 << 44)) >> 45);
    if (rgb[0] >= reg_q[REG_WHITE][15:0] && rgb[1] >= reg_q[REG_WHITE][15:0] &&
        rgb[2] >= reg_q[REG_WHITE][15:0]) return 1'b0;
    pt.wx = cell_centre(reg_q[REG_ORIGIN_X], v.cx, reg_q[REG_CELL_XY]);
    pt.wy = cell_centre(reg_q[REG_ORIGIN_Y], v.cy, reg_q[REG_CELL_XY]);
    pt.wz = cell_centre(reg_q[REG_FLOOR_Z], {2'b00, v.cz}, reg_q[REG_CELL_Z]);
    pt.r = rgb[0];
    pt.g = rgb[1];
    pt.b = rgb[2];
    pt.width = v.dens;
    return 1'b1;
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_WHITE) reg_q[idx] = {16'd0, data[15:0]};
    else if (idx < REG_WHITE + 1) reg_q[idx] = data;
  endtask

  // offer one voxel, maybe after a gap; record what it should emit
  task automatic send_voxel(voxel_t v, row_kind_e kind, point_t given);
    point_t pt;
    if (!quiet && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(v);
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == ROW_GIVEN) pending_pts.insert(pending_pts.size(), given);
    else if (kind == ROW_PRED && colorize(v, pt)) pending_pts.insert(pending_pts.size(), pt);
  endtask

  // wait out every in-flight voxel, emitting or not
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  function automatic voxel_t rand_voxel();
    voxel_t v;
    logic [31:0] pre [3];
    v.cx = 8'($urandom());
    v.cy = 8'($urandom());
    v.cz = 6'($urandom());
    case ($urandom_range(3))
      0: v.dens = rand_word();
      1: v.dens = $urandom_range(32, 2000);
      default: v.dens = $urandom_range(100, 32'h0020_0000);
    endcase
    for (int c = 0; c < 3; c++)
      case ($urandom_range(5))
        0: pre[c] = rand_word();
        1: pre[c] = 32'd0;
        2: pre[c] = v.dens;
        default: pre[c] = 32'((64'(v.dens) * $urandom_range(0, 1100)) / 1000);
      endcase
    v.red = pre[0];
    v.yellow = pre[1];
    v.blue = pre[2];
    return v;
  endfunction

  // drive ready: one long forced hold when asked, else random idling
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst_ni ? 1'b0 : (quiet || $urandom_range(99) >= 11);
    end
  end

  // accept and compare results
  always @(posedge clk_i) begin
    point_t got;
    point_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = point_t'(m_axis_tdata);
      if (pending_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point %h", got);
      end else begin
        want = pending_pts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: wx %h/%h wy %h/%h wz %h/%h rgb %h %h %h/%h %h %h w %h/%h",
                     want.wx, got.wx, want.wy, got.wy, want.wz, got.wz,
                     want.r, want.g, want.b, got.r, got.g, got.b, want.width, got.width);
        end
      end
    end
  end

  initial begin
    row_t   rows [$];
    voxel_t v;
    point_t none_pt;
    logic [31:0] dmax;
    none_pt = '0;
    dmax = 32'hFFFF_FFFF;
    reset_regs();

    // directed voxels under the reset settings
    rows.insert(rows.size(), '{'{0, 0, 0, 32'd0, 0, 0, 0}, ROW_NONE, none_pt});
    rows.insert(rows.size(), '{'{dmax, dmax, dmax, 32'd66, 0, 0, 0}, ROW_NONE, none_pt});
    rows.insert(rows.size(), '{'{0, 0, 0, 32'd67, 0, 0, 0}, ROW_NONE, none_pt});
    rows.insert(rows.size(), '{'{0, 0, 32'd65536, 32'd65536, 0, 0, 0}, ROW_GIVEN,
                     '{32'd65536, 16'd0, 16'd0, 16'd32768, 32'd32768, 32'd32768, 32'd32768}});
    rows.insert(rows.size(), '{'{0, 32'd65536, 0, 32'd65536, 0, 0, 0}, ROW_GIVEN,
                     '{32'd65536, 16'd0, 16'd32768, 16'd32768, 32'd32768, 32'd32768,
                       32'd32768}});
    rows.insert(rows.size(), '{'{32'd65536, 0, 0, 32'd65536, 0, 0, 0}, ROW_GIVEN,
                     '{32'd65536, 16'd19661, 16'd12222, 16'd5341, 32'd32768, 32'd32768,
                       32'd32768}});
    rows.insert(rows.size(), '{'{dmax, dmax, dmax, dmax, 6'd63, 8'd255, 8'd255}, ROW_GIVEN,
                     '{dmax, 16'd950, 16'd3080, 16'd6554, 32'd4161536, 32'd16744448,
                       32'd16744448}});
    rows.insert(rows.size(), '{'{dmax, dmax, dmax, 32'd67, 6'd17, 8'd3, 8'd200}, ROW_PRED,
                     none_pt});
    rows.insert(rows.size(), '{'{32'd32768, 32'd32768, 32'd32768, 32'd65536, 1, 2, 3},
                     ROW_PRED, none_pt});
    rows.insert(rows.size(), '{'{32'd0, 32'd30000, 32'd65536, 32'd65536, 9, 99, 9}, ROW_PRED,
                     none_pt});
    rows.insert(rows.size(), '{'{32'd20000, 0, 32'd50000, 32'd65536, 40, 0, 128}, ROW_PRED,
                     none_pt});
    rows.insert(rows.size(), '{'{32'd1000, 32'd1000, 32'd1000, 32'd65536, 5, 6, 7}, ROW_PRED,
                     none_pt});
    rows.insert(rows.size(), '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                       6'h2A, 8'h55, 8'hAA}, ROW_PRED, none_pt});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_voxel(rows[i].vox, rows[i].kind, rows[i].pt);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_CELL_XY, $urandom_range(1, 32'h0004_0000));
          write_reg(REG_CELL_Z, $urandom_range(1, 32'h0004_0000));
          write_reg(REG_ORIGIN_X, rand_word() >>> 8);
          write_reg(REG_ORIGIN_Y, rand_word() >>> 8);
          write_reg(REG_FLOOR_Z, rand_word() >>> 8);
          write_reg(REG_DENS_THR, $urandom_range(0, 500));
          write_reg(REG_WHITE, $urandom_range(20000, 32768));
        end
        1: begin
          // largest cells push centres past the top of the range
          write_reg(REG_CELL_XY, 32'hFFFF_FFFF);
          write_reg(REG_CELL_Z, 32'hFFFF_FFFF);
          write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
          write_reg(REG_ORIGIN_Y, 32'h8000_0000);
          write_reg(REG_FLOOR_Z, rand_word());
          write_reg(REG_DENS_THR, 32'd0);
          write_reg(REG_WHITE, 32'd32768);
        end
        2: begin
          // zero-size cells collapse x and y onto the origin
          write_reg(REG_CELL_XY, 32'd0);
          write_reg(REG_CELL_Z, 32'd1);
          write_reg(REG_ORIGIN_X, 32'h8000_0000);
          write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
          write_reg(REG_FLOOR_Z, 32'h8000_0000);
          write_reg(REG_WHITE, 32'h0001_FFFF);
          write_reg(REG_SPARE, rand_word());
        end
        3: begin
          // everything mixes to white
          write_reg(REG_WHITE, 32'd0);
          write_reg(REG_DENS_THR, 32'hFFFF_FFFE);
        end
        default: begin
          write_reg(REG_CELL_XY, rand_word());
          write_reg(REG_CELL_Z, rand_word());
          write_reg(REG_ORIGIN_X, rand_word());
          write_reg(REG_ORIGIN_Y, rand_word());
          write_reg(REG_FLOOR_Z, rand_word());
          write_reg(REG_DENS_THR, $urandom_range(0, 2000));
          write_reg(REG_WHITE, $urandom_range(0, 32768));
        end
      endcase
      for (int n = 0; n < ((ph == 3) ? 80 : 215); n++) begin
        quiet = (ph == 4 && n >= 40 && n < 140);
        if (ph == 0 && n == 20) hold_req = 1'b1;
        v = rand_voxel();
        if (ph == 3 && n < 5) v.dens = 32'hFFFF_FFFF;
        send_voxel(v, ROW_PRED, none_pt);
      end
      quiet = 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_pts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
